### rtl/msk_pkg.sv
// shared types and codes of the kruskal spanning tree unit
// no dependencies; used by every module of the block
package msk_pkg;

  localparam int VERTICES_DEF    = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  end_a;
    logic [3:0]  end_b;
    logic [15:0] weight;
  } item_t;

  typedef struct packed {
    logic [3:0]  tree_a;
    logic [3:0]  tree_b;
    logic [15:0] tree_weight;
    logic        last;
    logic        empty_res;
  } result_t;

endpackage

### rtl/msk_ram.sv
// simple dual port memory, one write and one registered read per cycle
// depends on msk_pkg only for house consistency
module msk_ram
  import msk_pkg::*;
#(
  parameter int W  = 16,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/msk_ctrl.sv
// sequencer: clear sweep, edge load, repeated min scan over the matrix,
// label compare and relabel sweep; drives both memories
// depends on msk_pkg
module msk_ctrl
  import msk_pkg::*;
#(
  parameter int VERTICES    = VERTICES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int IDX_W       = $clog2(VERTICES),
  parameter int CNT_W       = $clog2(VERTICES + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  item_t                    in_data,
  input  logic [CNT_W-1:0]         vcount,
  input  logic                     out_free,
  output logic                     res_push,
  output result_t                  res_data,
  output logic                     wm_we,
  output logic [2*IDX_W-1:0]       wm_waddr,
  output logic [WEIGHT_BITS-1:0]   wm_wdata,
  output logic [2*IDX_W-1:0]       wm_raddr,
  input  logic [WEIGHT_BITS-1:0]   wm_rdata,
  output logic                     lb_we,
  output logic [IDX_W-1:0]         lb_waddr,
  output logic [IDX_W-1:0]         lb_wdata,
  output logic [IDX_W-1:0]         lb_raddr,
  input  logic [IDX_W-1:0]         lb_rdata
);

  localparam int AW    = 2 * IDX_W;
  localparam int KEY_W = WEIGHT_BITS + AW;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_INIT  = 4'd2;
  localparam logic [3:0] ST_SCAN  = 4'd3;
  localparam logic [3:0] ST_LBLA  = 4'd4;
  localparam logic [3:0] ST_LBLB  = 4'd5;
  localparam logic [3:0] ST_CMP   = 4'd6;
  localparam logic [3:0] ST_PUSH  = 4'd7;
  localparam logic [3:0] ST_RELAB = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0]             state;
  logic [AW-1:0]          clr_addr;
  logic [IDX_W-1:0]       ri, ci, rd_i, rd_j, j, jd;
  logic                   rd_ok, scan_end, j_end, jd_ok;
  logic                   have_last, have_best;
  logic [KEY_W-1:0]       last_key, best_key;
  logic [IDX_W-1:0]       la, lb;
  logic                   pend_valid;
  logic [IDX_W-1:0]       pend_a, pend_b;
  logic [WEIGHT_BITS-1:0] pend_w;

  logic [IDX_W-1:0]       nlast, ia, ib, e_i, e_j;
  logic [WEIGHT_BITS-1:0] w_in, e_w;
  logic                   in_rng, load_go;
  logic [KEY_W-1:0]       cur_key;
  logic                   cand;
  logic [31:0]            w_in32, pw32;

  assign nlast  = IDX_W'(vcount - 1'b1);
  assign ia     = IDX_W'(in_data.end_a);
  assign ib     = IDX_W'(in_data.end_b);
  assign w_in32 = 32'(in_data.weight);
  assign w_in   = w_in32[WEIGHT_BITS-1:0];
  assign in_rng = (32'(in_data.end_a) < 32'(vcount)) && (32'(in_data.end_b) < 32'(vcount));
  assign load_go = (state == ST_IDLE) && in_valid && (in_data.cmd == CMD_LOAD) && in_rng;

  assign e_w = last_key[KEY_W-1 -: WEIGHT_BITS];
  assign e_i = last_key[AW-1 -: IDX_W];
  assign e_j = last_key[IDX_W-1:0];

  // key orders by weight, then row-major position, which keeps the sort stable
  assign cur_key = {wm_rdata, rd_i, rd_j};
  assign cand = rd_ok && (wm_rdata != '0) && (!have_last || cur_key > last_key)
                && (!have_best || cur_key < best_key);

  assign in_ready = (state == ST_IDLE);

  // weight matrix holds the upper triangle only, row = smaller endpoint
  always_comb begin
    wm_we    = (state == ST_CLEAR) || load_go;
    wm_waddr = (state == ST_CLEAR) ? clr_addr : ((ia <= ib) ? {ia, ib} : {ib, ia});
    wm_wdata = (state == ST_CLEAR) ? '0 : w_in;
    wm_raddr = {ri, ci};
  end

  always_comb begin
    lb_we    = (state == ST_INIT) || ((state == ST_RELAB) && jd_ok && (lb_rdata == lb));
    lb_waddr = (state == ST_INIT) ? j : jd;
    lb_wdata = (state == ST_INIT) ? j : la;
    unique case (state)
      ST_LBLA: lb_raddr = e_i;
      ST_LBLB: lb_raddr = e_j;
      default: lb_raddr = j;
    endcase
  end

  assign pw32 = 32'(pend_w);
  always_comb begin
    res_push = ((state == ST_PUSH) || (state == ST_FIN)) && out_free;
    res_data.tree_a      = pend_valid ? 4'(pend_a) : 4'd0;
    res_data.tree_b      = pend_valid ? 4'(pend_b) : 4'd0;
    res_data.tree_weight = pend_valid ? pw32[15:0] : 16'd0;
    res_data.last        = (state == ST_FIN);
    res_data.empty_res   = !pend_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      rd_ok      <= 1'b0;
      jd_ok      <= 1'b0;
      scan_end   <= 1'b0;
      j_end      <= 1'b0;
      have_last  <= 1'b0;
      have_best  <= 1'b0;
      pend_valid <= 1'b0;
      ri         <= '0;
      ci         <= '0;
      j          <= '0;
    end else begin
      rd_ok <= 1'b0;
      jd_ok <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.cmd == CMD_CLEAR) begin
              clr_addr <= '0;
              state    <= ST_CLEAR;
            end else if (in_data.cmd == CMD_RUN) begin
              j          <= '0;
              have_last  <= 1'b0;
              have_best  <= 1'b0;
              pend_valid <= 1'b0;
              state      <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          j <= j + 1'b1;
          if (j == nlast) begin
            ri       <= '0;
            ci       <= '0;
            scan_end <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!scan_end) begin
            rd_ok <= 1'b1;
            rd_i  <= ri;
            rd_j  <= ci;
            if (ci == nlast) begin
              if (ri == nlast) begin
                scan_end <= 1'b1;
              end else begin
                ri <= ri + 1'b1;
                ci <= ri + 1'b1;
              end
            end else begin
              ci <= ci + 1'b1;
            end
          end
          if (cand) begin
            best_key  <= cur_key;
            have_best <= 1'b1;
          end
          // pipeline drained: the best candidate of this pass is the next edge
          if (scan_end && !rd_ok) begin
            ri       <= '0;
            ci       <= '0;
            scan_end <= 1'b0;
            if (have_best) begin
              last_key  <= best_key;
              have_last <= 1'b1;
              have_best <= 1'b0;
              state     <= ST_LBLA;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_LBLA: state <= ST_LBLB;
        ST_LBLB: begin
          la    <= lb_rdata;
          state <= ST_CMP;
        end
        ST_CMP: begin
          lb <= lb_rdata;
          j  <= '0;
          j_end <= 1'b0;
          if (la == lb_rdata) begin
            state <= ST_SCAN;
          end else if (pend_valid) begin
            state <= ST_PUSH;
          end else begin
            pend_valid <= 1'b1;
            pend_a     <= e_i;
            pend_b     <= e_j;
            pend_w     <= e_w;
            state      <= ST_RELAB;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            pend_a <= e_i;
            pend_b <= e_j;
            pend_w <= e_w;
            state  <= ST_RELAB;
          end
        end
        ST_RELAB: begin
          if (!j_end) begin
            jd_ok <= 1'b1;
            jd    <= j;
            j     <= j + 1'b1;
            if (j == nlast) begin
              j_end <= 1'b1;
            end
          end
          if (j_end && !jd_ok) begin
            state <= ST_SCAN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/minimum_spanning_tree_kruskal_unit.sv
// channel | signals                      | transaction
// in      | in_valid in_ready in_data    | one command: clear, load edge or run
// out     | out_valid out_ready out_data | one tree edge, or one empty mark
// cfg     | cfg_valid cfg_ready cfg_data | vertex count write
// load writes one entry; clear sweeps the whole matrix memory, 4^ceil(log2 VERTICES)
// words (256 by default), and the same sweep runs after reset with in_ready low
// run: a label init sweep, then per sorted edge a scan pass of the n(n+1)/2 triangle
// entries over the single matrix read port and label reads of both ends; an accepted
// edge adds a relabel sweep, plus a push after the first; one more pass ends the run
// a stalled output holds the sequencer until the output register frees
// top level of the kruskal spanning tree unit; uses msk_pkg, msk_ram, msk_ctrl
module minimum_spanning_tree_kruskal_unit
  import msk_pkg::*;
#(
  parameter int VERTICES    = VERTICES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam int IDX_W = $clog2(VERTICES);
  localparam int CNT_W = $clog2(VERTICES + 1);

  logic [4:0]             vertex_count;
  logic [CNT_W-1:0]       vcount;
  logic                   out_free, res_push;
  result_t                res_data;
  logic                   wm_we;
  logic [2*IDX_W-1:0]     wm_waddr, wm_raddr;
  logic [WEIGHT_BITS-1:0] wm_wdata, wm_rdata;
  logic                   lb_we;
  logic [IDX_W-1:0]       lb_waddr, lb_wdata, lb_raddr, lb_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 5'd16;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  // zero acts as one, above the parameter acts as the parameter
  always_comb begin
    if (vertex_count == 5'd0) begin
      vcount = CNT_W'(1);
    end else if (32'(vertex_count) > 32'(VERTICES)) begin
      vcount = CNT_W'(VERTICES);
    end else begin
      vcount = CNT_W'(vertex_count);
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_data <= res_data;
    end
  end

  msk_ctrl #(
    .VERTICES    (VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .vcount   (vcount),
    .out_free (out_free),
    .res_push (res_push),
    .res_data (res_data),
    .wm_we    (wm_we),
    .wm_waddr (wm_waddr),
    .wm_wdata (wm_wdata),
    .wm_raddr (wm_raddr),
    .wm_rdata (wm_rdata),
    .lb_we    (lb_we),
    .lb_waddr (lb_waddr),
    .lb_wdata (lb_wdata),
    .lb_raddr (lb_raddr),
    .lb_rdata (lb_rdata)
  );

  msk_ram #(.W(WEIGHT_BITS), .AW(2*IDX_W)) u_wmat (
    .clk   (clk),
    .we    (wm_we),
    .waddr (wm_waddr),
    .wdata (wm_wdata),
    .raddr (wm_raddr),
    .rdata (wm_rdata)
  );

  msk_ram #(.W(IDX_W), .AW(IDX_W)) u_label (
    .clk   (clk),
    .we    (lb_we),
    .waddr (lb_waddr),
    .wdata (lb_wdata),
    .raddr (lb_raddr),
    .rdata (lb_rdata)
  );

endmodule

### rtl/msk_checker.sv
// port level checks of the kruskal spanning tree unit, bound to the top level
// depends on msk_pkg
module msk_checker
  import msk_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input item_t   in_data,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.empty_res |-> out_data.last && out_data.tree_a == 4'd0
      && out_data.tree_b == 4'd0 && out_data.tree_weight == 16'd0)
    else $error("empty result malformed");

  a_edge_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.empty_res |-> out_data.tree_weight != 16'd0
      && out_data.tree_a < out_data.tree_b)
    else $error("tree edge malformed");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.cmd == CMD_RUN || in_data.cmd == CMD_CLEAR)
      |=> !in_ready)
    else $error("input taken during run or clear");

endmodule

bind minimum_spanning_tree_kruskal_unit msk_checker u_msk_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
